// ===== design/crss_pkg.sv =====
// Shared widths, types and helpers of the Catmull-Rom stroke smoother.
`default_nettype none
package crss_pkg;

    localparam int unsigned NCH     = 4;        // x, y, time, distance
    localparam int unsigned CW      = 32;       // coordinate width
    localparam int unsigned PW      = CW + 1;   // point value with sign room
    localparam int unsigned KW      = PW + 4;   // spline coefficient
    localparam int unsigned TW      = 17;       // Q1.16 parameter t
    localparam int unsigned MW      = KW + TW + 1 - 16; // scaled product
    localparam int unsigned SW      = MW + 2;   // sum of terms
    localparam int unsigned RW      = 7;        // resolution register
    localparam int unsigned DW      = 7;        // divisor (resolution - 1)
    localparam int unsigned CH_TIME = 2;        // the unsigned channel

    // Largest resolution the step generator supports.
    localparam int unsigned MAX_RESOLUTION = 65;

    localparam logic [RW-1:0] RES_RESET = 7'd17;
    localparam logic [TW-1:0] T_ONE     = 17'h10000;

    typedef logic [PW-1:0] pt_t;

    // Four window points of all channels, oldest first.
    typedef struct packed {
        pt_t [NCH-1:0] p0;
        pt_t [NCH-1:0] p1;
        pt_t [NCH-1:0] p2;
        pt_t [NCH-1:0] p3;
    } job_t;

    // Widen a stored coordinate by one bit, by sign or by zero.
    function automatic pt_t ext_pt(input logic [CW-1:0] v, input logic is_signed);
        return {is_signed & v[CW-1], v};
    endfunction

endpackage
`default_nettype wire

// ===== design/crss_ifs.sv =====
// Valid/ready channel interfaces for stroke points and smoothed points.
`default_nettype none
interface crss_pt_if;
    logic        valid;
    logic        ready;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] time_req;
    logic [31:0] dist_req;
    logic        stroke_start;
    modport source (output valid, x, y, time_req, dist_req, stroke_start, input ready);
    modport sink   (input valid, x, y, time_req, dist_req, stroke_start, output ready);
endinterface

interface crss_smp_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_time;
    logic [31:0] out_dist;
    logic        last;
    modport source (output valid, out_x, out_y, out_time, out_dist, last, input ready);
    modport sink   (input valid, out_x, out_y, out_time, out_dist, last, output ready);
endinterface
`default_nettype wire

// ===== design/crss_front.sv =====
// Front end: keeps the stroke window and turns full windows into jobs.
`default_nettype none
module crss_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    crss_pt_if.sink            pnt,
    input  wire logic          emit_en,
    input  wire logic          push_ok,
    output logic               push,
    output crss_pkg::job_t     push_job
);
    import crss_pkg::*;

    localparam logic [2:0] SEEN_FULL = 3'd4;

    logic [2:0][NCH-1:0][CW-1:0] win_reg, win_next, win_eff;
    logic [2:0]                  seen_reg, seen_next, seen_eff;
    logic [NCH-1:0][CW-1:0]      np;
    logic                        accept;

    assign pnt.ready = push_ok;
    assign accept    = pnt.valid && pnt.ready;
    assign np        = {pnt.dist_req, pnt.time_req, pnt.y, pnt.x};

    // A stroke start empties the window before the new point is used.
    always_comb
    begin
        win_eff  = pnt.stroke_start ? '0 : win_reg;
        seen_eff = pnt.stroke_start ? 3'd0 : seen_reg;
        push     = accept && (seen_eff >= SEEN_FULL) && emit_en;
        for (int k = 0; k < NCH; k++)
        begin
            push_job.p0[k] = ext_pt(win_eff[0][k], k != CH_TIME);
            push_job.p1[k] = ext_pt(win_eff[1][k], k != CH_TIME);
            push_job.p2[k] = ext_pt(win_eff[2][k], k != CH_TIME);
            push_job.p3[k] = ext_pt(np[k], k != CH_TIME);
        end
        win_next  = {np, win_eff[2], win_eff[1]};
        seen_next = (seen_eff < SEEN_FULL) ? seen_eff + 3'd1 : seen_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/crss_queue.sv =====
// Two-entry job queue between the front end and the back end.
`default_nettype none
module crss_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  crss_pkg::job_t     push_job,
    output logic               push_ok,
    output logic               head_valid,
    output crss_pkg::job_t     head_job,
    input  wire logic          pop
);
    import crss_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign push_ok    = cnt_reg != 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head_job   = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) && !pop |=> cnt_reg == 2'd2)
        else $error("queue lost an entry");

endmodule
`default_nettype wire

// ===== design/crss_back.sv =====
// Back end: t stepping, power pipeline, per-channel spline lanes, output.
`default_nettype none
module crss_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [crss_pkg::DW-1:0] den,
    input  wire logic                    job_valid,
    input  crss_pkg::job_t               job,
    output logic                         job_pop,
    crss_smp_if.source                   smp
);
    import crss_pkg::*;

    localparam logic [4:0] DIV_LAST = 5'd16;

    // Divider for 65536 / den, rerun after reset and each config write.
    logic          div_busy_reg;
    logic [4:0]    div_cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [TW-1:0] quo_reg;
    logic [DW:0]   trial;
    logic          trial_ge;

    assign trial    = {rem_reg, div_cnt_reg == 5'd0};
    assign trial_ge = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else if (cfg_we)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
        end
        else if (div_busy_reg)
        begin
            rem_reg     <= trial_ge ? DW'(trial - {1'b0, den}) : DW'(trial);
            quo_reg     <= {quo_reg[TW-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (div_cnt_reg == DIV_LAST)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // Pipeline control: everything moves when the output can take a beat.
    logic en, out_valid_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg;
    logic pipe_empty, gen_start;

    assign en         = !out_valid_reg || smp.ready;
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    // Step generator for t = floor(i * 65536 / den).
    logic          gen_busy_reg;
    logic [DW-1:0] i_reg;
    logic [TW-1:0] t_reg;
    logic [DW-1:0] tr_reg;
    logic [DW:0]   tr_sum;
    logic          tr_carry, gen_last;

    assign gen_start = !gen_busy_reg && !div_busy_reg && job_valid && pipe_empty;
    assign job_pop   = gen_start;
    assign tr_sum    = {1'b0, tr_reg} + {1'b0, rem_reg};
    assign tr_carry  = tr_sum >= {1'b0, den};
    assign gen_last  = i_reg == den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_busy_reg <= 1'b0;
            i_reg        <= '0;
            t_reg        <= '0;
            tr_reg       <= '0;
        end
        else if (gen_start)
        begin
            gen_busy_reg <= 1'b1;
            i_reg        <= DW'(1);
            t_reg        <= quo_reg;
            tr_reg       <= rem_reg;
        end
        else if (gen_busy_reg && en)
        begin
            i_reg  <= i_reg + DW'(1);
            t_reg  <= t_reg + quo_reg + TW'(tr_carry);
            tr_reg <= tr_carry ? DW'(tr_sum - {1'b0, den}) : DW'(tr_sum);
            if (gen_last)
            begin
                gen_busy_reg <= 1'b0;
            end
        end
    end

    // Coefficients of the current window, loaded when a job starts.
    logic signed [KW-1:0] c1_reg [NCH];
    logic signed [KW-1:0] c2_reg [NCH];
    logic signed [KW-1:0] c3_reg [NCH];
    logic signed [PW:0]   p1x2_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (gen_start)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                c1_reg[k]   <= KW'($signed(job.p2[k])) - KW'($signed(job.p0[k]));
                c2_reg[k]   <= 2 * KW'($signed(job.p0[k])) - 5 * KW'($signed(job.p1[k]))
                             + 4 * KW'($signed(job.p2[k])) - KW'($signed(job.p3[k]));
                c3_reg[k]   <= 3 * KW'($signed(job.p1[k])) - KW'($signed(job.p0[k]))
                             - 3 * KW'($signed(job.p2[k])) + KW'($signed(job.p3[k]));
                p1x2_reg[k] <= 2 * (PW+1)'($signed(job.p1[k]));
            end
        end
    end

    // Powers of t, one multiply per stage.
    logic [TW-1:0]     ta1_reg, ta2_reg, ta3_reg;
    logic [TW-1:0]     tb2_reg, tb3_reg, tc3_reg;
    logic [2*TW-1:0]   sq_full, cu_full;

    assign sq_full = ta1_reg * ta1_reg;
    assign cu_full = tb2_reg * ta2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= gen_busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta1_reg <= t_reg;
            l1_reg  <= gen_last;
            ta2_reg <= ta1_reg;
            tb2_reg <= sq_full[TW+15:16];
            l2_reg  <= l1_reg;
            ta3_reg <= ta2_reg;
            tb3_reg <= tb2_reg;
            tc3_reg <= cu_full[TW+15:16];
            l3_reg  <= l2_reg;
        end
    end

    // Per-channel lanes: scaled products, then sum, halve and saturate.
    logic signed [MW-1:0]      m1_reg [NCH];
    logic signed [MW-1:0]      m2_reg [NCH];
    logic signed [MW-1:0]      m3_reg [NCH];
    logic signed [KW+TW:0]     pr1 [NCH];
    logic signed [KW+TW:0]     pr2 [NCH];
    logic signed [KW+TW:0]     pr3 [NCH];
    logic signed [SW-1:0]      sum [NCH];
    logic signed [SW-1:0]      half [NCH];
    logic [NCH-1:0][CW-1:0]    res;

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            pr1[k]  = c1_reg[k] * $signed({1'b0, ta3_reg});
            pr2[k]  = c2_reg[k] * $signed({1'b0, tb3_reg});
            pr3[k]  = c3_reg[k] * $signed({1'b0, tc3_reg});
            sum[k]  = SW'(p1x2_reg[k]) + SW'(m1_reg[k]) + SW'(m2_reg[k]) + SW'(m3_reg[k]);
            half[k] = sum[k] >>> 1;
            if (k == CH_TIME)
            begin
                if (half[k] < 0)
                    res[k] = '0;
                else if (half[k] > $signed({{(SW-CW){1'b0}}, {CW{1'b1}}}))
                    res[k] = '1;
                else
                    res[k] = half[k][CW-1:0];
            end
            else
            begin
                if (half[k] < $signed({{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}}))
                    res[k] = {1'b1, {(CW-1){1'b0}}};
                else if (half[k] > $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}}))
                    res[k] = {1'b0, {(CW-1){1'b1}}};
                else
                    res[k] = half[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                m1_reg[k] <= pr1[k][KW+TW:16];
                m2_reg[k] <= pr2[k][KW+TW:16];
                m3_reg[k] <= pr3[k][KW+TW:16];
            end
            l4_reg <= l3_reg;
        end
    end

    // Output register.
    logic [NCH-1:0][CW-1:0] out_reg;
    logic                   out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg      <= res;
            out_last_reg <= l4_reg;
        end
    end

    assign smp.valid    = out_valid_reg;
    assign smp.out_x    = out_reg[0];
    assign smp.out_y    = out_reg[1];
    assign smp.out_time = out_reg[2];
    assign smp.out_dist = out_reg[3];
    assign smp.last     = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) gen_busy_reg |-> t_reg <= T_ONE)
        else $error("t stepped past one");
    assert property (@(posedge clk) disable iff (!rst_n)
        gen_busy_reg |-> (i_reg >= DW'(1)) && (i_reg <= den))
        else $error("step index outside the window");
    assert property (@(posedge clk) disable iff (!rst_n) en && v4_reg |=> out_valid_reg)
        else $error("lane result dropped before the output");

endmodule
`default_nettype wire

// ===== design/catmull_rom_stroke_smoother_top.sv =====
// Top level of the Catmull-Rom stroke smoother.
//
//   Channel | Direction | Carries
//   pnt     | in        | x, y, time_req, dist_req, stroke_start
//   smo     | out       | out_x, out_y, out_time, out_dist, last
//   cfg     | in        | resolution (write only)
//
// A point that completes a window yields resolution-1 beats, one per cycle
// while the output is ready; the next window starts only once the lane
// pipeline has drained. After reset and after each resolution write the step
// divider runs before the next window starts. Output stalls freeze the whole
// back pipeline; the two-entry job queue keeps the front end taking points
// meanwhile, until the queue is full.
`default_nettype none
module catmull_rom_stroke_smoother_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    crss_pt_if.sink                      pnt,
    crss_smp_if.source                   smo,
    input  wire logic                    cfg_we,
    input  wire logic [crss_pkg::RW-1:0] cfg_data
);
    import crss_pkg::*;

    logic [RW-1:0] resolution_reg;
    logic [RW-1:0] res_eff;
    logic [DW-1:0] den;
    logic          emit_en, push, push_ok, head_valid, pop;
    job_t          push_job, head_job;

    // Resolution register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= RES_RESET;
        end
        else if (cfg_we)
        begin
            resolution_reg <= cfg_data;
        end
    end

    // Clamp to the supported maximum; below two nothing is emitted.
    always_comb
    begin
        if (9'(resolution_reg) > 9'(MAX_RESOLUTION))
            res_eff = RW'(MAX_RESOLUTION);
        else
            res_eff = resolution_reg;
        emit_en = res_eff >= RW'(2);
        den     = DW'(res_eff - RW'(1));
    end

    crss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pnt      (pnt),
        .emit_en  (emit_en),
        .push_ok  (push_ok),
        .push     (push),
        .push_job (push_job)
    );

    crss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ok    (push_ok),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    crss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .den       (den),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (pop),
        .smp       (smo)
    );

endmodule
`default_nettype wire

// ===== tb/catmull_rom_stroke_smoother_top_tb.sv =====
// Self-checking testbench of the Catmull-Rom stroke smoother top level.
`timescale 1ns / 1ps
`default_nettype none

// Smoothed-point scoreboard: predicts beats from accepted stroke points.
class crss_smooth_board;
    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] st;
        logic [31:0] sd;
        logic        lst;
    } beat_t;

    longint     win [4][3];
    int         pts_in_stroke;
    int         res_reg;
    beat_t      pending [$];
    int         mismatches;
    int         beats_ok;
    int         windows;

    function new();
        foreach (win[k, j]) win[k][j] = 0;
        pts_in_stroke = 0;
        res_reg = 17;
        mismatches = 0;
        beats_ok = 0;
        windows = 0;
    endfunction

    function void set_resolution(int v);
        res_reg = v & 8'h7F;
    endfunction

    // Floor of v*t/65536 with exact arithmetic for |v| below 2^40.
    function longint scaled_mul(longint v, longint t);
        longint hi;
        longint lo;
        hi = v >>> 16;
        lo = v - hi * 65536;
        return hi * t + ((lo * t) >>> 16);
    endfunction

    function longint spline(longint p0, longint p1, longint p2, longint p3,
                            longint t, longint t2, longint t3);
        longint c1;
        longint c2;
        longint c3;
        longint s;
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = -p0 + 3 * p1 - 3 * p2 + p3;
        s = 2 * p1 + scaled_mul(c1, t) + scaled_mul(c2, t2) + scaled_mul(c3, t3);
        return s >>> 1;
    endfunction

    function logic [31:0] clamp(longint v, bit sgn);
        if (sgn)
        begin
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
        end
        else
        begin
            if (v > 64'sd4294967295) v = 64'sd4294967295;
            if (v < 0) v = 0;
        end
        return v[31:0];
    endfunction

    // Note one accepted stroke point and queue the beats it causes.
    function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pt,
                             logic [31:0] pd, logic start);
        longint np [4];
        longint t;
        longint t2;
        longint t3;
        int res;
        beat_t b;
        np[0] = longint'(signed'(px));
        np[1] = longint'(signed'(py));
        np[2] = longint'({32'd0, pt});
        np[3] = longint'(signed'(pd));
        if (start)
        begin
            foreach (win[k, j]) win[k][j] = 0;
            pts_in_stroke = 0;
        end
        if (pts_in_stroke >= 4)
        begin
            res = (res_reg > 65) ? 65 : res_reg;
            if (res >= 2) windows++;
            for (int i = 1; i < res; i++)
            begin
                t = (longint'(i) * 65536) / (res - 1);
                t2 = (t * t) >>> 16;
                t3 = (t2 * t) >>> 16;
                b.sx = clamp(spline(win[0][0], win[0][1], win[0][2], np[0], t, t2, t3), 1);
                b.sy = clamp(spline(win[1][0], win[1][1], win[1][2], np[1], t, t2, t3), 1);
                b.st = clamp(spline(win[2][0], win[2][1], win[2][2], np[2], t, t2, t3), 0);
                b.sd = clamp(spline(win[3][0], win[3][1], win[3][2], np[3], t, t2, t3), 1);
                b.lst = (i == res - 1);
                pending = {pending, b};
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
            win[k][2] = np[k];
        end
        if (pts_in_stroke < 4) pts_in_stroke++;
    endfunction

    // Compare one accepted output beat with the oldest expectation.
    function void check_beat(beat_t got);
        beat_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat %h", got);
            return;
        end
        want = pending.pop_front();
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat mismatch: exp x=%h y=%h t=%h d=%h l=%b got x=%h y=%h t=%h d=%h l=%b",
                         want.sx, want.sy, want.st, want.sd, want.lst,
                         got.sx, got.sy, got.st, got.sd, got.lst);
        end
        else
            beats_ok++;
    endfunction
endclass

module catmull_rom_stroke_smoother_top_tb;
    import crss_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [RW-1:0] cfg_data;
    crss_pt_if  pnt ();
    crss_smp_if smo ();

    crss_smooth_board board;
    int  cycles;
    int  pts_sent;
    bit  calm;        // no idling in the last part of the run
    bit  hold_req;    // asks the receiver for one long hold-off
    int  hold_left;
    int  rx_gap;

    catmull_rom_stroke_smoother_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pnt      (pnt.sink),
        .smo      (smo.source),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("catmull_rom_stroke_smoother_top_tb: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smo.ready <= 1'b0;
            hold_left <= 0;
            rx_gap <= 0;
        end
        else
        begin
            if (smo.valid && smo.ready)
                board.check_beat({smo.out_x, smo.out_y, smo.out_time, smo.out_dist,
                                  smo.last});
            if (hold_req && hold_left == 0)
            begin
                hold_left <= 400;
                smo.ready <= 1'b0;
            end
            else if (hold_left > 1)
            begin
                hold_left <= hold_left - 1;
                smo.ready <= 1'b0;
            end
            else if (hold_left == 1)
            begin
                hold_left <= -1;
                smo.ready <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                smo.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rx_gap <= $urandom_range(0, 5);
                smo.ready <= 1'b0;
            end
            else
                smo.ready <= 1'b1;
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offer one point and wait until it is accepted; valid stays high afterwards
    // so that the next point can follow back to back.
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pt,
                              logic [31:0] pd, logic start);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            pnt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pnt.valid <= 1'b1;
        pnt.x <= px;
        pnt.y <= py;
        pnt.time_req <= pt;
        pnt.dist_req <= pd;
        pnt.stroke_start <= start;
        @(posedge clk);
        while (!pnt.ready) @(posedge clk);
        board.note_point(px, py, pt, pd, start);
        pts_sent++;
    endtask

    task automatic send_random_point(logic start);
        send_point(rand_field(), rand_field(), rand_field(), rand_field(), start);
    endtask

    // Stop offering, wait until every expected beat has come, then let the
    // pipeline settle.
    task automatic drain();
        pnt.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_resolution(int v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v[RW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_resolution(v);
        repeat (20) @(posedge clk);
    endtask

    // Random strokes: mostly long well-formed strokes, some short ones.
    task automatic stroke_burst(int count);
        int left;
        int len;
        left = count;
        while (left > 0)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
            for (int j = 0; j < len && left > 0; j++)
            begin
                send_random_point(j == 0 || $urandom_range(0, 40) == 0);
                left--;
            end
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        pts_sent = 0;
        calm = 0;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        pnt.valid = 1'b0;
        pnt.x = '0;
        pnt.y = '0;
        pnt.time_req = '0;
        pnt.dist_req = '0;
        pnt.stroke_start = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (25) @(posedge clk);

        // Directed: extremes at reset resolution, including a never-started stroke.
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0, 1'b0);
        // Stroke start clears the window; short stroke yields nothing.
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        for (int j = 0; j < 5; j++) send_random_point(1'b0);

        // Resolution extremes: below two, two, maximum, above maximum.
        write_resolution(0);
        for (int j = 0; j < 3; j++) send_random_point(1'b0);
        write_resolution(1);
        send_random_point(1'b0);
        write_resolution(2);
        for (int j = 0; j < 3; j++) send_random_point(1'b0);
        write_resolution(65);
        send_random_point(1'b0);
        write_resolution(127);
        send_random_point(1'b0);

        // Random phases over several resolutions, mostly small ones.
        write_resolution(5);
        fork
            begin
                repeat (30) @(posedge clk);
                hold_req = 1;
                repeat (3) @(posedge clk);
                hold_req = 0;
            end
            stroke_burst(80);
        join
        drain();
        write_resolution(3);
        stroke_burst(100);
        write_resolution(17);
        stroke_burst(60);
        write_resolution($urandom_range(2, 9));
        stroke_burst(100);
        write_resolution(4);
        calm = 1;
        stroke_burst(80);

        drain();
        $display("sent %0d points, %0d windows, %0d beats matched, resolutions 0..127",
                 pts_sent, board.windows, board.beats_ok);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("catmull_rom_stroke_smoother_top_tb: clean");
        else
            $display("catmull_rom_stroke_smoother_top_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
